// ===== hdl/stopg_pkg.sv =====
`default_nettype none

package stopg_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_SCALE      = 3'd2,
        CFG_LENGTH     = 3'd3,
        CFG_TEXT_COLOR = 3'd4,
        CFG_BORD_COLOR = 3'd5,
        CFG_BACK_COLOR = 3'd6
    } t_cfg_idx;

    // input word kinds
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // register reset values
    localparam logic signed [11:0] RST_ORIGIN_X   = 12'sd13;
    localparam logic signed [11:0] RST_ORIGIN_Y   = 12'sd109;
    localparam logic [3:0]         RST_SCALE      = 4'd3;
    localparam logic [4:0]         RST_LENGTH     = 5'd0;
    localparam logic [15:0]        RST_TEXT_COLOR = 16'hFFE0;
    localparam logic [15:0]        RST_BORD_COLOR = 16'h07FF;
    localparam logic [15:0]        RST_BACK_COLOR = 16'h000F;

    // font geometry
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_PITCH = 6;

    // codes that have a glyph
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_L    = 8'h4C;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_W    = 8'h57;

    // five columns of seven dots, column 0 in the low slice, top row in bit 0
    typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] t_glyph;

    function automatic t_glyph glyph_cols(input logic [7:0] code);
        t_glyph g;
        case (code)
            CH_BANG: g = {7'h00, 7'h00, 7'h5F, 7'h00, 7'h00};
            CH_D:    g = {7'h1C, 7'h22, 7'h41, 7'h41, 7'h7F};
            CH_E:    g = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F};
            CH_H:    g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
            CH_L:    g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F};
            CH_O:    g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
            CH_R:    g = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F};
            CH_W:    g = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/scaled_text_overlay_pixel_gen_core.sv =====
`default_nettype none

// Text overlay pixel generator. Each input word either stores a character code
// into a text slot (mode 0, no result) or asks for the RGB565 color of one pixel
// (mode 1, one result word). The block takes one word every clock while o_ready
// is high (back-pressure from i_ready can hold it low). A pixel result passes
// through the entry stage, loaded by the edge that accepts its word, then one
// pipeline stage per quotient bit of the character-slot divider, a slot-read
// stage and a color stage. Slot writes travel down the same pipeline and take
// effect at the slot-read stage, so every pixel sees exactly the writes accepted
// before it. Configuration writes are always taken (o_cfg_ready is tied high)
// and must be issued with no pixel in flight. Text slots clear to blank on reset
// through per-slot valid flags.
module scaled_text_overlay_pixel_gen_core #(
    parameter int FRAME_WIDTH  = 240,
    parameter int FRAME_HEIGHT = 240,
    parameter int MAX_CHARS    = 16,
    parameter int BORDER_INSET = 8,
    parameter int BORDER_THICK = 3
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input words
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_mode,
    input  wire logic [3:0]                        i_slot_index,
    input  wire logic [7:0]                        i_char_code,
    input  wire logic [7:0]                        i_pixel_x,
    input  wire logic [7:0]                        i_pixel_y,
    // result words
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [15:0]                            o_pixel_color,
    output logic                                   o_on_glyph,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [stopg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [stopg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import stopg_pkg::*;

    // quotient bits of the slot divider, slot store depth, divider word width
    localparam int QW         = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int SLOT_DEPTH = 1 << QW;
    localparam int CW         = QW + 13;

    // border box corners
    localparam int OX0 = BORDER_INSET;
    localparam int OX1 = FRAME_WIDTH - BORDER_INSET;
    localparam int OY0 = BORDER_INSET;
    localparam int OY1 = FRAME_HEIGHT - BORDER_INSET;
    localparam int IX0 = OX0 + BORDER_THICK;
    localparam int IX1 = OX1 - BORDER_THICK;
    localparam int IY0 = OY0 + BORDER_THICK;
    localparam int IY1 = OY1 - BORDER_THICK;

    typedef struct packed {
        logic          mode;
        logic [3:0]    wslot;
        logic [7:0]    code;
        logic          miss;
        logic          border;
        logic [CW-1:0] rem;
        logic [QW-1:0] quo;
        logic [11:0]   dy;
        logic [2:0]    row;
    } t_div;

    typedef struct packed {
        logic       mode;
        logic       miss;
        logic       border;
        logic [2:0] row;
        logic [2:0] col;
    } t_chr;

    // configuration registers
    logic signed [11:0] r_text_origin_x;
    logic signed [11:0] r_text_origin_y;
    logic [3:0]         r_glyph_scale;
    logic [4:0]         r_text_length;
    logic [15:0]        r_text_color;
    logic [15:0]        r_border_color;
    logic [15:0]        r_background_color;

    // pipeline
    t_div        r_dv  [QW+1];
    t_div        n_dv  [QW+1];
    logic [QW:0] r_dvv;
    logic [QW:0] en_dv;
    t_chr        r_c;
    t_chr        n_c;
    logic        r_cv;
    logic        en_c;
    logic        en_o;
    logic        r_ov;
    logic [15:0] r_pixel_color;
    logic        r_on_glyph;

    // slot store
    logic [7:0]            r_slot_mem [SLOT_DEPTH];
    logic [SLOT_DEPTH-1:0] r_slot_set;
    logic [7:0]            r_rd_code;
    logic                  r_rd_ok;

    logic [6:0]  pitch;
    logic        s1_miss;
    logic [2:0]  s1_row;
    logic [QW-1:0] waddr;
    logic        wslot_ok;
    t_glyph      glyph;
    logic        dot_hit;

    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_ov;
    assign o_pixel_color = r_pixel_color;
    assign o_on_glyph    = r_on_glyph;
    assign o_ready       = en_dv[0];

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_origin_x    <= RST_ORIGIN_X;
            r_text_origin_y    <= RST_ORIGIN_Y;
            r_glyph_scale      <= RST_SCALE;
            r_text_length      <= RST_LENGTH;
            r_text_color       <= RST_TEXT_COLOR;
            r_border_color     <= RST_BORD_COLOR;
            r_background_color <= RST_BACK_COLOR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:   r_text_origin_x    <= $signed(i_cfg_data[11:0]);
                CFG_ORIGIN_Y:   r_text_origin_y    <= $signed(i_cfg_data[11:0]);
                CFG_SCALE:      r_glyph_scale      <= i_cfg_data[3:0];
                CFG_LENGTH:     r_text_length      <= i_cfg_data[4:0];
                CFG_TEXT_COLOR: r_text_color       <= i_cfg_data;
                CFG_BORD_COLOR: r_border_color     <= i_cfg_data;
                CFG_BACK_COLOR: r_background_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // character pitch in pixels
    assign pitch = 7'(GLYPH_PITCH * r_glyph_scale);

    // stall chain: a stage loads when empty or when its word moves on
    always_comb begin
        en_o = !r_ov || i_ready;
        en_c = !r_cv || en_o;
        en_dv[QW] = !r_dvv[QW] || en_c;
        for (int k = QW - 1; k >= 0; k--) begin
            en_dv[k] = !r_dvv[k] || en_dv[k+1];
        end
    end

    // entry stage: offsets from the text origin, frame and border tests
    always_comb begin
        logic signed [12:0] dx;
        logic signed [12:0] dy;
        logic               in_frame;
        logic               outer;
        logic               inner;
        dx = $signed({5'b0, i_pixel_x}) - $signed({r_text_origin_x[11], r_text_origin_x});
        dy = $signed({5'b0, i_pixel_y}) - $signed({r_text_origin_y[11], r_text_origin_y});
        in_frame = (int'(i_pixel_x) < FRAME_WIDTH) && (int'(i_pixel_y) < FRAME_HEIGHT);
        outer = (int'(i_pixel_x) >= OX0) && (int'(i_pixel_x) < OX1) &&
                (int'(i_pixel_y) >= OY0) && (int'(i_pixel_y) < OY1);
        inner = (int'(i_pixel_x) >= IX0) && (int'(i_pixel_x) < IX1) &&
                (int'(i_pixel_y) >= IY0) && (int'(i_pixel_y) < IY1);
        n_dv[0].mode   = i_mode;
        n_dv[0].wslot  = i_slot_index;
        n_dv[0].code   = i_char_code;
        n_dv[0].miss   = dx[12] || dy[12] || (r_glyph_scale == 4'd0) || !in_frame;
        n_dv[0].border = outer && !inner;
        n_dv[0].rem    = CW'(dx[11:0]);
        n_dv[0].quo    = '0;
        n_dv[0].dy     = dy[11:0];
        n_dv[0].row    = '0;
    end

    // first divider stage also finds the glyph row and the slot overflow
    always_comb begin
        logic [11:0] m;
        s1_row  = '0;
        for (int k = 1; k < GLYPH_ROWS; k++) begin
            m = 12'(k * r_glyph_scale);
            s1_row = s1_row + 3'(r_dv[0].dy >= m);
        end
        m = 12'(GLYPH_ROWS * r_glyph_scale);
        s1_miss = (r_dv[0].dy >= m) || (r_dv[0].rem >= (CW'(pitch) << QW));
    end

    // restoring divider of the column offset by the pitch, one bit per stage
    for (genvar k = 1; k <= QW; k++) begin : g_div
        always_comb begin
            logic [CW-1:0] sh;
            n_dv[k] = r_dv[k-1];
            sh = CW'(pitch) << (QW - k);
            if (r_dv[k-1].rem >= sh) begin
                n_dv[k].rem        = r_dv[k-1].rem - sh;
                n_dv[k].quo[QW-k]  = 1'b1;
            end
            n_dv[k].miss = r_dv[k-1].miss || ((k == 1) ? s1_miss : 1'b0);
            n_dv[k].row  = (k == 1) ? s1_row : r_dv[k-1].row;
        end
    end

    // divider pipeline registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv <= '0;
        end else begin
            if (en_dv[0]) begin
                r_dvv[0] <= i_valid;
            end
            for (int k = 1; k <= QW; k++) begin
                if (en_dv[k]) begin
                    r_dvv[k] <= r_dvv[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= QW; k++) begin
            if (en_dv[k]) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // column within the character, slot range check
    always_comb begin
        logic [CW-1:0] m;
        logic          col_miss;
        logic          slot_ok;
        n_c.mode   = r_dv[QW].mode;
        n_c.border = r_dv[QW].border;
        n_c.row    = r_dv[QW].row;
        n_c.col    = '0;
        for (int k = 1; k < GLYPH_COLS; k++) begin
            m = CW'(k * r_glyph_scale);
            n_c.col = n_c.col + 3'(r_dv[QW].rem >= m);
        end
        m = CW'(GLYPH_COLS * r_glyph_scale);
        col_miss = r_dv[QW].rem >= m;
        slot_ok  = (int'(r_dv[QW].quo) < int'(r_text_length)) &&
                   (int'(r_dv[QW].quo) < MAX_CHARS);
        n_c.miss = r_dv[QW].miss || col_miss || !slot_ok;
    end

    assign waddr    = QW'(r_dv[QW].wslot);
    assign wslot_ok = int'(r_dv[QW].wslot) < MAX_CHARS;

    // slot store: writes and reads happen in pipeline order at this stage
    always_ff @(posedge i_clk) begin
        if (en_c && r_dvv[QW]) begin
            if (r_dv[QW].mode == MODE_WRITE) begin
                if (wslot_ok) begin
                    r_slot_mem[waddr] <= r_dv[QW].code;
                end
            end else begin
                r_rd_code <= r_slot_mem[r_dv[QW].quo];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_set <= '0;
            r_rd_ok    <= 1'b0;
            r_cv       <= 1'b0;
        end else if (en_c) begin
            r_cv <= r_dvv[QW];
            if (r_dvv[QW]) begin
                if (r_dv[QW].mode == MODE_WRITE) begin
                    if (wslot_ok) begin
                        r_slot_set[waddr] <= 1'b1;
                    end
                end else begin
                    r_rd_ok <= r_slot_set[r_dv[QW].quo];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c <= n_c;
        end
    end

    // glyph lookup
    always_comb begin
        glyph   = glyph_cols(r_rd_code);
        dot_hit = !r_c.miss && r_rd_ok && glyph[r_c.col][r_c.row];
    end

    // color select into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_o) begin
            r_ov <= r_cv && (r_c.mode == MODE_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_on_glyph <= dot_hit;
            if (dot_hit) begin
                r_pixel_color <= r_text_color;
            end else if (r_c.border) begin
                r_pixel_color <= r_border_color;
            end else begin
                r_pixel_color <= r_background_color;
            end
        end
    end

    // a glyph dot always carries the text color
    a_dot_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_on_glyph |-> o_pixel_color == r_text_color)
        else $error("glyph dot without text color");

    // a pixel that can still hit text leaves the divider with a remainder below the pitch
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dvv[QW] && (r_dv[QW].mode == MODE_PIXEL) && !r_dv[QW].miss
        |-> r_dv[QW].rem < CW'(pitch))
        else $error("divider remainder out of range");

    // a stalled divider word is not dropped and keeps its quotient
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dvv[QW] && !en_c |=> r_dvv[QW] && $stable(r_dv[QW].quo))
        else $error("stalled divider word lost");

endmodule

`default_nettype wire
